@@ rtl/mlk_pkg.sv @@
// Shared types, register indexes and the Morse pattern table for the keyer.
`default_nettype none
package mlk_pkg;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned SYM_CNT_W = 3;
   localparam int unsigned SYM_BITS_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_DOT_TICKS        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DASH_TICKS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_GAP_TICKS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_GAP_TICKS = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

   // One classified character: symbol count (zero for a non-letter) and the
   // symbols first to last from bit 0 upward, 1 meaning dash.
   typedef struct packed {
      logic [SYM_CNT_W-1:0]  sym_count;
      logic [SYM_BITS_W-1:0] sym_bits;
   } letter_type;

   typedef struct packed {
      logic [TICK_W-1:0] dot_ticks;
      logic [TICK_W-1:0] dash_ticks;
      logic [TICK_W-1:0] symbol_gap_ticks;
      logic [TICK_W-1:0] letter_gap_ticks;
   } csr_type;

   function automatic letter_type morse_lookup(input logic [4:0] idx);
      letter_type l;
      case (idx)
         5'd0: l = '{3'd2, 4'h2};
         5'd1: l = '{3'd4, 4'h1};
         5'd2: l = '{3'd4, 4'h5};
         5'd3: l = '{3'd3, 4'h1};
         5'd4: l = '{3'd1, 4'h0};
         5'd5: l = '{3'd4, 4'h4};
         5'd6: l = '{3'd3, 4'h3};
         5'd7: l = '{3'd4, 4'h0};
         5'd8: l = '{3'd2, 4'h0};
         5'd9: l = '{3'd4, 4'hE};
         5'd10: l = '{3'd3, 4'h5};
         5'd11: l = '{3'd4, 4'h2};
         5'd12: l = '{3'd2, 4'h3};
         5'd13: l = '{3'd2, 4'h1};
         5'd14: l = '{3'd3, 4'h7};
         5'd15: l = '{3'd4, 4'h6};
         5'd16: l = '{3'd4, 4'hB};
         5'd17: l = '{3'd3, 4'h2};
         5'd18: l = '{3'd3, 4'h0};
         5'd19: l = '{3'd1, 4'h1};
         5'd20: l = '{3'd3, 4'h4};
         5'd21: l = '{3'd4, 4'h8};
         5'd22: l = '{3'd3, 4'h6};
         5'd23: l = '{3'd4, 4'h9};
         5'd24: l = '{3'd4, 4'hD};
         5'd25: l = '{3'd4, 4'h3};
         default: l = '{3'd0, 4'h0};
      endcase
      return l;
   endfunction

endpackage
`default_nettype wire

@@ rtl/morse_letter_keyer_core.sv @@
// Top level of the Morse letter keyer: registers, front end, queue and back end.
`default_nettype none
// The keyer takes one ASCII character per transfer on the req_ channel and
// returns its Morse code as a run of key segments on the rsp_ channel, each
// segment carrying a key level, a duration in ticks and a last flag. Letters
// are matched without regard to case; every dot or dash yields a key-down
// segment followed by a key-up symbol gap, and each character closes with a
// key-up letter gap segment marked last. Any other code yields only that
// closing segment. The back end emits one segment per clock while rsp_ready
// is high, so a character of n symbols yields 2n+1 segments, at most nine,
// and that output sequencer sets the sustained rate. The front end classifies
// a character in the cycle it arrives and parks it in a queue of QUEUE_DEPTH
// entries, so new characters are taken while earlier ones are still being
// keyed and while a finished segment waits to be taken. The four duration
// registers are written through the csr_ port (index 0 dot, 1 dash, 2 symbol
// gap, 3 letter gap) and should only change while the keyer is idle.
module morse_letter_keyer_core
   import mlk_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]    csr_wr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CHAR_W-1:0]    req_char_code,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_key_level,
   output logic [TICK_W-1:0]         rsp_duration_ticks,
   output logic                      rsp_last_segment
);

   csr_type    csr_ff;
   logic       q_full;
   logic       q_empty;
   logic       q_push;
   logic       q_pop;
   letter_type q_wr_entry;
   letter_type q_rd_entry;

   // Duration registers; reset values give the classic 1:3 dot to dash ratio.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.dot_ticks        <= TICK_W'(1);
         csr_ff.dash_ticks       <= TICK_W'(3);
         csr_ff.symbol_gap_ticks <= TICK_W'(1);
         csr_ff.letter_gap_ticks <= TICK_W'(2);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DOT_TICKS:        csr_ff.dot_ticks        <= csr_wr_data;
            CSR_DASH_TICKS:       csr_ff.dash_ticks       <= csr_wr_data;
            CSR_SYMBOL_GAP_TICKS: csr_ff.symbol_gap_ticks <= csr_wr_data;
            CSR_LETTER_GAP_TICKS: csr_ff.letter_gap_ticks <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // The front end turns a character into a symbol count and dash mask.
   mlk_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_wr_entry    (q_wr_entry)
   );

   // The queue decouples acceptance from keying so each side stalls alone.
   mlk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .rd_entry (q_rd_entry)
   );

   // The back end steps through symbols and gaps, one segment per transfer.
   mlk_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr_ff),
      .q_empty            (q_empty),
      .q_rd_entry         (q_rd_entry),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_level      (rsp_key_level),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_last_segment   (rsp_last_segment)
   );

endmodule
`default_nettype wire

@@ rtl/mlk_front.sv @@
// Front end: accepts characters and classifies them into Morse patterns.
`default_nettype none
module mlk_front
   import mlk_pkg::*;
(
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [CHAR_W-1:0] req_char_code,
   input  wire logic              q_full,
   output logic                   q_push,
   output letter_type             q_wr_entry
);

   logic       is_upper;
   logic       is_lower;
   logic [CHAR_W-1:0] offset;
   letter_type pattern;

   always_comb begin
      is_upper = (req_char_code >= CHAR_UPPER_A) && (req_char_code <= CHAR_UPPER_Z);
      is_lower = (req_char_code >= CHAR_LOWER_A) && (req_char_code <= CHAR_LOWER_Z);
      offset   = is_lower ? (req_char_code - CHAR_LOWER_A) : (req_char_code - CHAR_UPPER_A);
      pattern  = morse_lookup(offset[4:0]);
      if (is_upper || is_lower) begin
         q_wr_entry = pattern;
      end else begin
         // Anything else sends only the letter gap.
         q_wr_entry = '{'0, '0};
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule
`default_nettype wire

@@ rtl/mlk_queue.sv @@
// Short queue of classified characters between the front and back ends.
`default_nettype none
module mlk_queue
   import mlk_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  letter_type      wr_entry,
   output logic            full,
   input  wire logic       pop,
   output logic            empty,
   output letter_type      rd_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   letter_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign rd_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule
`default_nettype wire

@@ rtl/mlk_back.sv @@
// Back end: walks one pattern and emits its key segments through an output register.
`default_nettype none
module mlk_back
   import mlk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  csr_type                csr,
   input  wire logic              q_empty,
   input  letter_type             q_rd_entry,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_key_level,
   output logic [TICK_W-1:0]      rsp_duration_ticks,
   output logic                   rsp_last_segment
);

   logic                  active_ff, active_in;
   logic [SYM_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SYM_BITS_W-1:0] bits_ff, bits_in;
   logic                  gap_ff, gap_in;
   logic                  valid_ff, valid_in;
   logic                  level_ff, level_in;
   logic [TICK_W-1:0]     ticks_ff, ticks_in;
   logic                  last_ff, last_in;

   logic                  advance;
   logic [SYM_CNT_W-1:0]  cur_cnt;
   logic [SYM_BITS_W-1:0] cur_bits;
   logic                  cur_gap;

   always_comb begin
      advance  = !valid_ff || rsp_ready;
      q_pop    = advance && !active_ff && !q_empty;
      cur_cnt  = active_ff ? cnt_ff  : q_rd_entry.sym_count;
      cur_bits = active_ff ? bits_ff : q_rd_entry.sym_bits;
      cur_gap  = active_ff && gap_ff;

      active_in = active_ff;
      cnt_in    = cnt_ff;
      bits_in   = bits_ff;
      gap_in    = gap_ff;
      valid_in  = valid_ff;
      level_in  = level_ff;
      ticks_in  = ticks_ff;
      last_in   = last_ff;

      if (advance) begin
         if (active_ff || !q_empty) begin
            valid_in = 1'b1;
            if (cur_cnt == '0) begin
               level_in  = 1'b0;
               ticks_in  = csr.letter_gap_ticks;
               last_in   = 1'b1;
               active_in = 1'b0;
            end else if (!cur_gap) begin
               level_in  = 1'b1;
               ticks_in  = cur_bits[0] ? csr.dash_ticks : csr.dot_ticks;
               last_in   = 1'b0;
               active_in = 1'b1;
               cnt_in    = cur_cnt;
               bits_in   = cur_bits;
               gap_in    = 1'b1;
            end else begin
               level_in  = 1'b0;
               ticks_in  = csr.symbol_gap_ticks;
               last_in   = 1'b0;
               active_in = 1'b1;
               cnt_in    = cur_cnt - 1'b1;
               bits_in   = cur_bits >> 1;
               gap_in    = 1'b0;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         gap_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         gap_ff    <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      bits_ff  <= bits_in;
      level_ff <= level_in;
      ticks_ff <= ticks_in;
      last_ff  <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_key_level      = level_ff;
   assign rsp_duration_ticks = ticks_ff;
   assign rsp_last_segment   = last_ff;

endmodule
`default_nettype wire

@@ test/keyer_segment_checker.sv @@
`timescale 1ns / 100ps
// Segment checker for the Morse keyer: predicts the key segments of each character and compares.
module keyer_segment_checker
   import mlk_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]    csr_wr_data,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [CHAR_W-1:0]    req_char_code,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic                 rsp_key_level,
   input  wire logic [TICK_W-1:0]    rsp_duration_ticks,
   input  wire logic                 rsp_last_segment,
   output int                        fail_count,
   output int                        outstanding
);

   localparam logic KEY_DOWN = 1'b1;
   localparam logic KEY_UP   = 1'b0;

   localparam csr_type DURATION_DEFAULTS = '{
      dot_ticks: 16'd1, dash_ticks: 16'd3, symbol_gap_ticks: 16'd1, letter_gap_ticks: 16'd2
   };

   typedef struct packed {
      logic              level;
      logic [TICK_W-1:0] ticks;
      logic              closing;
   } key_segment_type;

   csr_type         durations;
   key_segment_type segments_due [$];
   key_segment_type oldest;
   int              mismatches = 0;

   // International Morse code for A..Z, written first symbol first.
   function automatic string morse_pattern(input int unsigned idx);
      case (idx)
         0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
         4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
         8: return "..";     9: return ".---";  10: return "-.-";   11: return ".-..";
        12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
        16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
        20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
        24: return "-.--";  25: return "--..";
         default: return "";
      endcase
   endfunction

   function automatic void queue_character(input logic [CHAR_W-1:0] code);
      string pattern;
      pattern = "";
      if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z)
         pattern = morse_pattern(code - CHAR_UPPER_A);
      else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z)
         pattern = morse_pattern(code - CHAR_LOWER_A);
      for (int i = 0; i < pattern.len(); i++) begin
         segments_due.push_back('{KEY_DOWN,
            (pattern[i] == "-") ? durations.dash_ticks : durations.dot_ticks, 1'b0});
         segments_due.push_back('{KEY_UP, durations.symbol_gap_ticks, 1'b0});
      end
      segments_due.push_back('{KEY_UP, durations.letter_gap_ticks, 1'b1});
   endfunction

   task automatic compare_field(input string field, input logic [TICK_W-1:0] want_v,
                                input logic [TICK_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         durations = DURATION_DEFAULTS;
         segments_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DOT_TICKS:        durations.dot_ticks        = csr_wr_data;
               CSR_DASH_TICKS:       durations.dash_ticks       = csr_wr_data;
               CSR_SYMBOL_GAP_TICKS: durations.symbol_gap_ticks = csr_wr_data;
               CSR_LETTER_GAP_TICKS: durations.letter_gap_ticks = csr_wr_data;
               default: ;
            endcase
         end
         // The character is queued first so that a segment leaving in the same
         // cycle still lines up with the oldest expectation.
         if (req_valid && req_ready)
            queue_character(req_char_code);
         if (rsp_valid && rsp_ready) begin
            if (segments_due.size() == 0) begin
               $display("%0t: segment with no character pending, expected none, actual level %0b ticks %0d last %0b",
                        $time, rsp_key_level, rsp_duration_ticks, rsp_last_segment);
               mismatches++;
            end else begin
               oldest = segments_due.pop_front();
               compare_field("key_level", oldest.level, rsp_key_level);
               compare_field("duration_ticks", oldest.ticks, rsp_duration_ticks);
               compare_field("last_segment", oldest.closing, rsp_last_segment);
            end
         end
      end
      fail_count  <= mismatches;
      outstanding <= segments_due.size();
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the Morse keyer testbench: clock, reset, stimulus, watchdog and verdict.
module tb_top;
   import mlk_pkg::*;

   // A run of cycles without any transfer on either channel that reaches this
   // limit means the keyer has hung. Normal gaps (register writes, the final
   // drain, random stalls) stay far below it.
   localparam int WATCHDOG_LIMIT  = 2000;
   // Cycles allowed after the last expected segment for stray extra segments
   // to show up: a full queue of characters of nine segments each.
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 26;

   localparam logic [TICK_W-1:0] TICKS_MAX = 16'hFFFF;

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [TICK_W-1:0]    csr_wr_data   = '0;
   logic                 req_valid     = 1'b0;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic                 rsp_ready     = 1'b0;

   logic                 req_ready;
   logic                 rsp_valid;
   logic                 rsp_key_level;
   logic [TICK_W-1:0]    rsp_duration_ticks;
   logic                 rsp_last_segment;

   int fail_count;
   int outstanding;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   // Directed characters: both ends of each letter range and their outer
   // neighbors, the extremes of the code, codes of 128 and above, and letters
   // with one symbol, with four symbols, all dots and all dashes.
   logic [CHAR_W-1:0] directed_chars [$] = '{
      8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40, 8'h5B, 8'h60, 8'h7B,
      8'h00, 8'h7F, 8'h80, 8'hFF, 8'h45, 8'h54, 8'h48, 8'h4A,
      8'h51, 8'h59, 8'h4F, 8'h6D, 8'h73, 8'h30
   };

   always #5 clock = ~clock;

   morse_letter_keyer_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_level      (rsp_key_level),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_last_segment   (rsp_last_segment)
   );

   keyer_segment_checker u_segment_check (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_key_level      (rsp_key_level),
      .rsp_duration_ticks (rsp_duration_ticks),
      .rsp_last_segment   (rsp_last_segment),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   // The receiver stalls on each cycle with the probability of the current
   // phase. With a stall rate of zero the rsp_ channel is always ready.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: count cycles in which neither channel completes a transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Offer one character. The sender may sit idle first, one cycle at a time,
   // with valid low. Once valid is raised it stays high with the same code
   // until the transfer, and it is left high afterward so that back-to-back
   // characters never see valid drop and rise within one time step.
   task automatic send_char(input logic [CHAR_W-1:0] code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Stop sending and wait until every predicted segment has been taken. The
   // first edge lets the checker count a character accepted at the last edge.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // One register write; the enable is left high so that a following write
   // can take the very next cycle, and the caller lowers it at the end.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   task automatic program_durations(input logic [TICK_W-1:0] dot, input logic [TICK_W-1:0] dash,
                                    input logic [TICK_W-1:0] sym_gap,
                                    input logic [TICK_W-1:0] letter_gap);
      write_reg(CSR_DOT_TICKS, dot);
      write_reg(CSR_DASH_TICKS, dash);
      write_reg(CSR_SYMBOL_GAP_TICKS, sym_gap);
      write_reg(CSR_LETTER_GAP_TICKS, letter_gap);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly letters of either case, since they exercise the symbol sequencer;
   // the rest is any 8-bit code, which is usually a non-letter.
   function automatic logic [CHAR_W-1:0] pick_char();
      logic [CHAR_W-1:0] base;
      if ($urandom_range(99) < 70) begin
         base = $urandom_range(1) ? CHAR_LOWER_A : CHAR_UPPER_A;
         return base + CHAR_W'($urandom_range(25));
      end
      return CHAR_W'($urandom_range(255));
   endfunction

   initial begin
      int phase;
      int n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed characters run on the reset durations with no idling.
      foreach (directed_chars[i])
         send_char(directed_chars[i]);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         // The durations only change while the keyer is idle.
         wait_drained();
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         // The first phases pin every register at its low end, its high end
         // and at zero, which must pass through as it is. Later phases pick the
         // durations at random.
         case (phase)
            0: program_durations(16'd1, 16'd1, 16'd1, 16'd1);
            1: program_durations(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
            2: program_durations(16'd0, 16'd0, 16'd0, 16'd0);
            3: program_durations(16'd1, TICKS_MAX, 16'd0, TICKS_MAX);
            default: program_durations(TICK_W'($urandom_range(65535)),
                                       TICK_W'($urandom_range(65535)),
                                       TICK_W'($urandom_range(65535)),
                                       TICK_W'($urandom_range(65535)));
         endcase
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // In every other phase the sender holds off halfway until the
            // keyer has handed over every segment it owes.
            if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 1)
               wait_drained();
            send_char(pick_char());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
